// ===== rtl/core/fbc_pkg.sv =====
package fbc_pkg;

    localparam int NUM_PLANES = 5;
    localparam int PSEL_W     = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int PIDX_W     = 3;
    localparam int COORD_W    = 32;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int OFF_SHIFT  = 30;
    localparam int OFF_EXT_W  = ACC_W - COORD_W - OFF_SHIFT;
    localparam int SIGN_BIT   = 31;
    localparam int NUM_AXES   = 3;

    localparam int S_TDATA_W  = 328;
    localparam int M_TDATA_W  = 8;

    localparam logic [PSEL_W-1:0] PLANE_LAST   = PSEL_W'(NUM_PLANES - 1);
    localparam logic [PIDX_W-1:0] VISIBLE_CODE = PIDX_W'(NUM_PLANES);
    localparam logic [1:0]        AXIS_LAST    = 2'(NUM_AXES - 1);
    localparam logic [1:0]        AXIS_FIRST   = 2'd0;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TEST = 1'b1
    } req_type_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_CMP,
        ST_DONE
    } state_t;

    // first member sits in the highest bits, so the list runs from max_z down
    typedef struct packed {
        logic [NUM_AXES-1:0][COORD_W-1:0] box_max;
        logic [NUM_AXES-1:0][COORD_W-1:0] box_min;
        logic [COORD_W-1:0]               plane_offset;
        logic [NUM_AXES-1:0][COORD_W-1:0] normal;
        logic [PIDX_W-1:0]                plane_index;
    } in_item_t;

    localparam int IN_ITEM_W = $bits(in_item_t);

    typedef struct packed {
        logic              plane_load;
        logic              box_load;
        logic              mul_en;
        logic              acc_clr;
        logic              acc_add;
        logic              res_load;
        logic              res_visible;
        logic [PIDX_W-1:0] res_plane;
        logic [PSEL_W-1:0] plane;
        logic [1:0]        axis;
    } dp_cmd_t;

    typedef struct packed {
        logic below;
    } dp_status_t;

endpackage

// ===== rtl/core/frustum_box_cull.sv =====
// channel  direction  tdata                                         tuser
// s_       in         plane_index, normal_x..z, plane_offset,       req_type
//                     min_x..z, max_x..z (323 bits in 328)
// m_       out        visible, culling_plane (4 bits in 8)          -
//
// a load transaction gives no result
// a test examines the planes in turn, each with three products on the one shared
// 32x32 multiplier, the last add and the compare, until one culls the box or all pass
// reset (aresetn low) clears the controller state and the output valid; planes stay
// undefined until loaded
// the result sits in an output register; a new transaction is taken while it
// waits, and a finished test waits only for that register to free up
module frustum_box_cull (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // plane_index, normal_x, normal_y, normal_z, plane_offset,
    // min_x, min_y, min_z, max_x, max_y, max_z, zero fill
    input  logic [fbc_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // visible, culling_plane, zero fill
    output logic [fbc_pkg::M_TDATA_W-1:0]   m_tdata
);

    fbc_pkg::in_item_t    in_item;
    fbc_pkg::req_type_t   req_type;
    fbc_pkg::dp_cmd_t     cmd;
    fbc_pkg::dp_status_t  status;

    assign in_item  = fbc_pkg::in_item_t'(s_tdata[fbc_pkg::IN_ITEM_W-1:0]);
    assign req_type = fbc_pkg::req_type_t'(s_tuser);

    fbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (req_type),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fbc_dp u_dp (
        .aclk     (aclk),
        .in_item  (in_item),
        .cmd      (cmd),
        .status   (status),
        .res_data (m_tdata)
    );

`ifndef SYNTHESIS
    // a test transaction holds off the input until its result is built
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == fbc_pkg::REQ_TEST) |=> !s_tready)
        else $error("input taken while a test is in progress");

    // a load transaction never produces a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == fbc_pkg::REQ_LOAD && !m_tvalid) |=> !m_tvalid)
        else $error("result raised by a plane load");

    // visible results carry the plane count, culled ones a real plane
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] ? (m_tdata[3:1] == fbc_pkg::VISIBLE_CODE)
                                 : (m_tdata[3:1] < fbc_pkg::VISIBLE_CODE)))
        else $error("culling plane does not match visible flag");
`endif

endmodule

// ===== rtl/core/fbc_dp.sv =====
module fbc_dp (
    input  logic                                   aclk,
    input  fbc_pkg::in_item_t                      in_item,
    input  fbc_pkg::dp_cmd_t                       cmd,
    output fbc_pkg::dp_status_t                    status,
    output logic [fbc_pkg::M_TDATA_W-1:0]          res_data
);

    logic [fbc_pkg::NUM_AXES-1:0][fbc_pkg::COORD_W-1:0] normal_mem [fbc_pkg::NUM_PLANES];
    logic [fbc_pkg::COORD_W-1:0]  offset_mem [fbc_pkg::NUM_PLANES];
    logic [fbc_pkg::NUM_AXES-1:0] csel_mem   [fbc_pkg::NUM_PLANES];

    logic [fbc_pkg::NUM_AXES-1:0][fbc_pkg::COORD_W-1:0] box_min_reg;
    logic [fbc_pkg::NUM_AXES-1:0][fbc_pkg::COORD_W-1:0] box_max_reg;

    logic signed [fbc_pkg::PROD_W-1:0] prod_reg;
    logic signed [fbc_pkg::ACC_W-1:0]  acc_reg;
    logic                              res_visible_reg;
    logic [fbc_pkg::PIDX_W-1:0]        res_plane_reg;

    logic                              load_ok;
    logic [fbc_pkg::PSEL_W-1:0]        load_idx;
    logic [fbc_pkg::NUM_AXES-1:0]      csel;
    logic                              neg;
    logic [fbc_pkg::COORD_W-1:0]       coord;
    logic [fbc_pkg::COORD_W-1:0]       normal;
    logic [fbc_pkg::COORD_W-1:0]       offset;
    logic signed [fbc_pkg::ACC_W-1:0]  off_scaled;

    function automatic logic [1:0] AXIS_IDX(input logic [1:0] axis);
        AXIS_IDX = fbc_pkg::AXIS_LAST - axis;
    endfunction

    assign load_ok  = {1'b0, in_item.plane_index} < (fbc_pkg::PIDX_W + 1)'(fbc_pkg::NUM_PLANES);
    assign load_idx = in_item.plane_index[fbc_pkg::PSEL_W-1:0];

    // bit2 holds the x sign, bit0 the z sign
    always_ff @(posedge aclk) begin
        if (cmd.plane_load && load_ok) begin
            normal_mem[load_idx] <= in_item.normal;
            offset_mem[load_idx] <= in_item.plane_offset;
            csel_mem[load_idx]   <= {in_item.normal[0][fbc_pkg::SIGN_BIT],
                                     in_item.normal[1][fbc_pkg::SIGN_BIT],
                                     in_item.normal[2][fbc_pkg::SIGN_BIT]};
        end
        if (cmd.box_load) begin
            box_min_reg <= in_item.box_min;
            box_max_reg <= in_item.box_max;
        end
    end

    // probe corner: min coordinate where the normal component is negative
    assign csel   = csel_mem[cmd.plane];
    assign neg    = csel[AXIS_IDX(cmd.axis)];
    assign coord  = neg ? box_min_reg[cmd.axis] : box_max_reg[cmd.axis];
    assign normal = normal_mem[cmd.plane][cmd.axis];
    assign offset = offset_mem[cmd.plane];

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= $signed(normal) * $signed(coord);
        end
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + fbc_pkg::ACC_W'(prod_reg);
        end
        if (cmd.res_load) begin
            res_visible_reg <= cmd.res_visible;
            res_plane_reg   <= cmd.res_plane;
        end
    end

    // offset moved from Q16.16 to the Q.46 scale of the products
    assign off_scaled = {{fbc_pkg::OFF_EXT_W{offset[fbc_pkg::SIGN_BIT]}}, offset,
                         fbc_pkg::OFF_SHIFT'(0)};

    assign status.below = acc_reg < off_scaled;

    assign res_data = fbc_pkg::M_TDATA_W'({res_plane_reg, res_visible_reg});

endmodule

// ===== rtl/core/fbc_ctrl.sv =====
module fbc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  fbc_pkg::req_type_t   req_type,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  fbc_pkg::dp_status_t  status,
    output fbc_pkg::dp_cmd_t     cmd
);

    fbc_pkg::state_t             state_reg, state_next;
    logic [fbc_pkg::PSEL_W-1:0]  plane_reg, plane_next;
    logic [1:0]                  axis_reg, axis_next;
    logic                        vis_reg, vis_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fbc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        plane_reg <= plane_next;
        axis_reg  <= axis_next;
        vis_reg   <= vis_next;
    end

    assign s_tready = (state_reg == fbc_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        plane_next      = plane_reg;
        axis_next       = axis_reg;
        vis_next        = vis_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        cmd             = '0;
        cmd.plane       = plane_reg;
        cmd.axis        = axis_reg;
        cmd.res_visible = vis_reg;
        cmd.res_plane   = vis_reg ? fbc_pkg::VISIBLE_CODE : fbc_pkg::PIDX_W'(plane_reg);
        unique case (state_reg)
            fbc_pkg::ST_IDLE: begin
                if (accept) begin
                    if (req_type == fbc_pkg::REQ_TEST) begin
                        cmd.box_load = 1'b1;
                        plane_next   = '0;
                        axis_next    = fbc_pkg::AXIS_FIRST;
                        state_next   = fbc_pkg::ST_MUL;
                    end else begin
                        cmd.plane_load = 1'b1;
                    end
                end
            end
            fbc_pkg::ST_MUL: begin
                cmd.mul_en = 1'b1;
                if (axis_reg == fbc_pkg::AXIS_FIRST) begin
                    cmd.acc_clr = 1'b1;
                end else begin
                    cmd.acc_add = 1'b1;
                end
                if (axis_reg == fbc_pkg::AXIS_LAST) begin
                    state_next = fbc_pkg::ST_ADD;
                end else begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            fbc_pkg::ST_ADD: begin
                cmd.acc_add = 1'b1;
                state_next  = fbc_pkg::ST_CMP;
            end
            fbc_pkg::ST_CMP: begin
                priority if (status.below) begin
                    vis_next   = 1'b0;
                    state_next = fbc_pkg::ST_DONE;
                end else if (plane_reg == fbc_pkg::PLANE_LAST) begin
                    vis_next   = 1'b1;
                    state_next = fbc_pkg::ST_DONE;
                end else begin
                    plane_next = plane_reg + fbc_pkg::PSEL_W'(1);
                    axis_next  = fbc_pkg::AXIS_FIRST;
                    state_next = fbc_pkg::ST_MUL;
                end
            end
            fbc_pkg::ST_DONE: begin
                // wait until the output register is free
                if (!m_valid_reg || m_tready) begin
                    cmd.res_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = fbc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fbc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
